// ----- hdl/gdsr_pkg.sv -----
// shared types, record codes and the payload size rule for the layout stream checker
package gdsr_pkg;

  // record types with special handling
  localparam logic [7:0] T_BGNLIB   = 8'd1;
  localparam logic [7:0] T_ENDLIB   = 8'd4;
  localparam logic [7:0] T_BGNSTR   = 8'd5;
  localparam logic [7:0] T_ENDSTR   = 8'd7;
  localparam logic [7:0] T_BOUNDARY = 8'd8;
  localparam logic [7:0] T_PATH     = 8'd9;
  localparam logic [7:0] T_TEXT     = 8'd12;
  localparam logic [7:0] T_XY       = 8'd16;
  localparam logic [7:0] T_NODE     = 8'd21;
  localparam logic [7:0] T_BOX      = 8'd45;
  localparam logic [7:0] NO_TYPE    = 8'hFF;

  // data type codes
  localparam logic [7:0] DT_NONE  = 8'd0;
  localparam logic [7:0] DT_BITS  = 8'd1;
  localparam logic [7:0] DT_INT2  = 8'd2;
  localparam logic [7:0] DT_INT4  = 8'd3;
  localparam logic [7:0] DT_REAL4 = 8'd4;
  localparam logic [7:0] DT_REAL8 = 8'd5;
  localparam logic [7:0] DT_ASCII = 8'd6;

  // fixed payload size of library and structure headers
  localparam logic [15:0] BGN_PAYLOAD = 16'd24;
  localparam logic [15:0] HDR_BYTES   = 16'd4;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PADDING = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_ODD_LEN   = 4'd1;
  localparam logic [3:0] ST_BAD_TYPE  = 4'd2;
  localparam logic [3:0] ST_SHORT     = 4'd3;
  localparam logic [3:0] ST_SIZE      = 4'd4;
  localparam logic [3:0] ST_UNK_DTYPE = 4'd5;
  localparam logic [3:0] ST_TRUNC     = 4'd6;
  localparam logic [3:0] ST_ODD_FILE  = 4'd7;
  localparam logic [3:0] ST_NO_ENDLIB = 4'd8;
  localparam logic [3:0] ST_PAD_NZ    = 4'd9;

  // element counter slots
  localparam int N_ELEM = 5;
  localparam int EL_BOUNDARY = 0;
  localparam int EL_PATH     = 1;
  localparam int EL_TEXT     = 2;
  localparam int EL_NODE     = 3;
  localparam int EL_BOX      = 4;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_PADDING,
    PH_HALTED
  } phase_t;

  typedef logic [15:0] count_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  rec_type;
    logic [7:0]  payload_type;
    logic [15:0] rec_length;
    logic [31:0] rec_number;
    logic [3:0]  status;
    count_t      boundary_total;
    count_t      path_total;
    count_t      text_total;
    count_t      node_total;
    count_t      box_total;
    logic        last_of_run;
  } res_t;

  // up to two results written per byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t       e0;
    res_t       e1;
  } res_push_t;

  // payload size rule of a data type
  function automatic logic [3:0] size_status(input logic [7:0] rtype,
                                             input logic [7:0] dtype,
                                             input logic [15:0] pay);
    logic [3:0] st;
    st = ST_OK;
    if (pay == 16'd0) begin
      st = (dtype == DT_NONE) ? ST_OK : ST_SIZE;
    end else begin
      case (dtype)
        DT_NONE:  st = ST_SIZE;
        DT_BITS:  st = pay[0] ? ST_SIZE : ST_OK;
        DT_INT2: begin
          if (rtype == T_BGNLIB || rtype == T_BGNSTR)
            st = (pay != BGN_PAYLOAD) ? ST_SIZE : ST_OK;
          else
            st = pay[0] ? ST_SIZE : ST_OK;
        end
        DT_INT4: begin
          if (rtype == T_XY)
            st = (pay[2:0] != 3'd0) ? ST_SIZE : ST_OK;
          else
            st = (pay[1:0] != 2'd0) ? ST_SIZE : ST_OK;
        end
        DT_REAL4: st = ST_SIZE;
        DT_REAL8: st = (pay[2:0] != 3'd0) ? ST_SIZE : ST_OK;
        DT_ASCII: st = ST_OK;
        default:  st = ST_UNK_DTYPE;
      endcase
    end
    return st;
  endfunction

endpackage

// ----- hdl/gdsr_core.sv -----
// record header assembly, checks, element counts and end of stream summary
module gdsr_core import gdsr_pkg::*; #(
  parameter int RECORD_TYPE_COUNT = 57
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  output res_push_t  push
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hidx_r, hidx_nxt;
  logic [23:0] hdr_r, hdr_nxt;
  logic [15:0] pleft_r, pleft_nxt;
  logic [31:0] rcnt_r, rcnt_nxt;
  logic        parity_r, parity_nxt;
  logic [7:0]  prev_r, prev_nxt;
  count_t      elem_r [N_ELEM];
  count_t      elem_nxt [N_ELEM];
  logic        padnz_r, padnz_nxt;

  // header decode
  logic [15:0] len;
  logic [7:0]  rtype;
  logic        hdr_done;
  logic        bad_type;
  logic        pad_hdr;
  logic        fatal;
  logic [3:0]  hdr_status;
  logic [1:0]  hdr_kind;
  logic [15:0] pay;
  logic [15:0] pleft_dec;
  logic [3:0]  sum_status;
  res_t        hdr_res, sum_res;

  assign len      = hdr_r[23:8];
  assign rtype    = hdr_r[7:0];
  assign hdr_done = (phase_r == PH_HEADER) && (hidx_r == 2'd3);
  assign bad_type = {1'b0, rtype} >= 9'(RECORD_TYPE_COUNT);
  assign pad_hdr  = (len == 16'd0) && (rtype == 8'd0) && (data_byte == 8'd0);
  assign pay      = len - HDR_BYTES;
  assign pleft_dec = (pleft_r != 16'd0) ? pleft_r - 16'd1 : pleft_r;

  // header status
  always_comb begin
    hdr_kind   = KIND_HEADER;
    hdr_status = ST_OK;
    if (bad_type) begin
      hdr_status = ST_BAD_TYPE;
    end else if (len < HDR_BYTES) begin
      if (pad_hdr) hdr_kind = KIND_PADDING;
      else hdr_status = ST_SHORT;
    end else begin
      hdr_status = size_status(rtype, data_byte, pay);
      if (hdr_status == ST_OK && len[0]) hdr_status = ST_ODD_LEN;
    end
  end

  assign fatal = (hdr_status >= ST_BAD_TYPE);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEADER: begin
        if (hdr_done) begin
          if (fatal) phase_nxt = PH_HALTED;
          else if (hdr_kind == KIND_PADDING) phase_nxt = PH_PADDING;
          else if (pay != 16'd0) phase_nxt = PH_PAYLOAD;
          else if (rtype == T_ENDLIB) phase_nxt = PH_PADDING;
        end
      end
      PH_PAYLOAD: begin
        if (pleft_dec == 16'd0)
          phase_nxt = (prev_r == T_ENDLIB) ? PH_PADDING : PH_HEADER;
      end
      PH_PADDING: phase_nxt = PH_PADDING;
      PH_HALTED:  phase_nxt = PH_HALTED;
      default:    phase_nxt = PH_HEADER;
    endcase
  end

  // datapath state updates
  always_comb begin
    hidx_nxt   = hidx_r;
    hdr_nxt    = hdr_r;
    pleft_nxt  = pleft_r;
    rcnt_nxt   = rcnt_r;
    parity_nxt = ~parity_r;
    prev_nxt   = prev_r;
    padnz_nxt  = padnz_r;
    for (int i = 0; i < N_ELEM; i++) elem_nxt[i] = elem_r[i];
    case (phase_r)
      PH_HEADER: begin
        if (!hdr_done) begin
          hdr_nxt  = {hdr_r[15:0], data_byte};
          hidx_nxt = hidx_r + 2'd1;
        end else begin
          hidx_nxt = 2'd0;
          hdr_nxt  = '0;
          if (rcnt_r != 32'hFFFF_FFFF) rcnt_nxt = rcnt_r + 32'd1;
          prev_nxt = rtype;
          if (!fatal && hdr_kind == KIND_HEADER) begin
            pleft_nxt = pay;
            case (rtype)
              T_BGNSTR: for (int i = 0; i < N_ELEM; i++) elem_nxt[i] = '0;
              T_BOUNDARY: if (elem_r[EL_BOUNDARY] != 16'hFFFF)
                elem_nxt[EL_BOUNDARY] = elem_r[EL_BOUNDARY] + 16'd1;
              T_PATH: if (elem_r[EL_PATH] != 16'hFFFF)
                elem_nxt[EL_PATH] = elem_r[EL_PATH] + 16'd1;
              T_TEXT: if (elem_r[EL_TEXT] != 16'hFFFF)
                elem_nxt[EL_TEXT] = elem_r[EL_TEXT] + 16'd1;
              T_NODE: if (elem_r[EL_NODE] != 16'hFFFF)
                elem_nxt[EL_NODE] = elem_r[EL_NODE] + 16'd1;
              T_BOX: if (elem_r[EL_BOX] != 16'hFFFF)
                elem_nxt[EL_BOX] = elem_r[EL_BOX] + 16'd1;
              default: ;
            endcase
          end
        end
      end
      PH_PAYLOAD: pleft_nxt = pleft_dec;
      PH_PADDING: if (data_byte != 8'd0) padnz_nxt = 1'b1;
      PH_HALTED:  ;
      default:    ;
    endcase
  end

  // summary status, first that applies
  always_comb begin
    if (parity_nxt)
      sum_status = ST_ODD_FILE;
    else if (phase_nxt == PH_HALTED)
      sum_status = ST_OK;
    else if ((phase_nxt == PH_HEADER && hidx_nxt != 2'd0) ||
             (phase_nxt == PH_PAYLOAD && pleft_nxt != 16'd0))
      sum_status = ST_TRUNC;
    else if (prev_nxt != T_ENDLIB)
      sum_status = ST_NO_ENDLIB;
    else if (padnz_nxt)
      sum_status = ST_PAD_NZ;
    else
      sum_status = ST_OK;
  end

  // result assembly
  always_comb begin
    hdr_res              = '0;
    hdr_res.kind         = hdr_kind;
    hdr_res.rec_type     = rtype;
    hdr_res.payload_type = data_byte;
    hdr_res.rec_length   = len;
    hdr_res.rec_number   = rcnt_nxt;
    hdr_res.status       = hdr_status;
    if (hdr_kind == KIND_HEADER && rtype == T_ENDSTR) begin
      hdr_res.boundary_total = elem_nxt[EL_BOUNDARY];
      hdr_res.path_total     = elem_nxt[EL_PATH];
      hdr_res.text_total     = elem_nxt[EL_TEXT];
      hdr_res.node_total     = elem_nxt[EL_NODE];
      hdr_res.box_total      = elem_nxt[EL_BOX];
    end
    hdr_res.last_of_run  = !is_last;

    sum_res             = '0;
    sum_res.kind        = KIND_SUMMARY;
    sum_res.rec_number  = rcnt_nxt;
    sum_res.status      = sum_status;
    sum_res.last_of_run = 1'b1;

    push = '0;
    if (req) begin
      if (hdr_done && is_last) begin
        push.cnt = 2'd2;
        push.e0  = hdr_res;
        push.e1  = sum_res;
      end else if (hdr_done) begin
        push.cnt = 2'd1;
        push.e0  = hdr_res;
      end else if (is_last) begin
        push.cnt = 2'd1;
        push.e0  = sum_res;
      end
    end
  end

  // state registers, cleared again after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (req && is_last)) begin
      phase_r  <= PH_HEADER;
      hidx_r   <= 2'd0;
      hdr_r    <= '0;
      pleft_r  <= '0;
      rcnt_r   <= '0;
      parity_r <= 1'b0;
      prev_r   <= NO_TYPE;
      padnz_r  <= 1'b0;
      for (int i = 0; i < N_ELEM; i++) elem_r[i] <= '0;
    end else if (req) begin
      phase_r  <= phase_nxt;
      hidx_r   <= hidx_nxt;
      hdr_r    <= hdr_nxt;
      pleft_r  <= pleft_nxt;
      rcnt_r   <= rcnt_nxt;
      parity_r <= parity_nxt;
      prev_r   <= prev_nxt;
      padnz_r  <= padnz_nxt;
      for (int i = 0; i < N_ELEM; i++) elem_r[i] <= elem_nxt[i];
    end
  end

endmodule

// ----- hdl/gdsr_fifo.sv -----
// four-entry result queue taking up to two results per cycle
module gdsr_fifo import gdsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_push_t push,
  output logic      room,
  output logic      rd_valid,
  input  logic      rd_ready,
  output res_t      rd_data
);

  res_t       mem [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign rd_valid = (count_r != 3'd0);
  assign rd_data  = mem[rd_ptr_r];
  assign room     = (count_r <= 3'd2);
  assign pop      = rd_valid && rd_ready;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.cnt;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push.cnt} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry writes
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr_ptr_r] <= push.e0;
    if (push.cnt == 2'd2) mem[wr_ptr_r + 2'd1] <= push.e1;
  end

endmodule

// ----- hdl/gdsii_record_stream_checker.sv -----
// Layout stream record checker: takes one byte of the stream file per clock on the
// in_ channel and emits one result per assembled record header, one per padding
// start and a summary after the byte marked by in_tlast, after which all state
// returns to reset. Each byte is checked in the cycle it is accepted and its
// results (at most two) enter a four-entry queue that drives the out_ channel, so
// the sustained rate is one byte per clock while results are taken; in_tready drops
// only when the queue has fewer than two free entries. Results are written into the
// queue registers and reach the output from there, behind any older results.
module gdsii_record_stream_checker import gdsr_pkg::*; #(
  parameter int RECORD_TYPE_COUNT = 57
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,   // is_last
  output logic         out_tvalid,
  input  logic         out_tready,
  // rec_type, payload_type, rec_length, rec_number, status, boundary_total,
  // path_total, text_total, node_total, box_total, zero fill
  output logic [151:0] out_tdata,
  output logic [1:0]   out_tuser,  // kind
  output logic         out_tlast   // last_of_run
);

  res_push_t push;
  res_t      head;
  logic      req;

  assign req = in_tvalid && in_tready;

  // byte checker
  gdsr_core #(
    .RECORD_TYPE_COUNT(RECORD_TYPE_COUNT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .data_byte (in_tdata),
    .is_last   (in_tlast),
    .push      (push)
  );

  // result queue
  gdsr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (in_tready),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (head)
  );

  // pack result fields, lowest first
  assign out_tdata = {4'b0, head.box_total, head.node_total, head.text_total,
                      head.path_total, head.boundary_total, head.status,
                      head.rec_number, head.rec_length, head.payload_type,
                      head.rec_type};
  assign out_tuser = head.kind;
  assign out_tlast = head.last_of_run;

endmodule
